// ===== src/plst_pkg.sv =====
// plst_pkg: shared constants, command codes and the cell control struct
// for the positional list. No dependencies.
`timescale 1ns / 1ps

package plst_pkg;

   // Storage sizing
   localparam int CAPACITY = 64;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int CMD_W    = 2;
   localparam int POS_W    = 7;
   // Common width for position / count compares, one spare bit for count+1
   localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

   // Locate encoder grouping
   localparam int GRP      = 8;
   localparam int GRP_W    = 3;
   localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOCATE = 2'd2;

   // Broadcast control to every cell of the chain
   typedef struct packed {
      logic              ins_en;
      logic              del_en;
      logic              loc_en;
      logic [CMP_W-1:0]  pos;
      logic [CMP_W-1:0]  count;
      logic [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage

// ===== src/plst_cell.sv =====
// plst_cell: one list slot. Holds a word, shifts with its neighbors on
// insert/delete and flags a match on locate. Depends on plst_pkg.
`timescale 1ns / 1ps

module plst_cell
   import plst_pkg::*;
(
   input  logic              clock,
   input  cell_ctrl_type     ctrl,
   input  logic [IDX_W-1:0]  cell_index,
   input  logic [DATA_W-1:0] left_data,
   input  logic [DATA_W-1:0] right_data,
   output logic [DATA_W-1:0] data_out,
   output logic              match_out,
   output logic [DATA_W-1:0] tap_out
);

   logic [DATA_W-1:0] data_ff, data_in;
   logic              match_ff, match_in;
   logic [CMP_W-1:0]  slot_pos;
   logic              at_pos, above_pos;

   // 1-based position of this slot
   assign slot_pos  = CMP_W'(cell_index) + CMP_W'(1);
   assign at_pos    = (slot_pos == ctrl.pos);
   assign above_pos = (slot_pos > ctrl.pos);

   // Next word: load, take from left on insert, take from right on delete
   always_comb begin
      data_in = data_ff;
      if (ctrl.ins_en) begin
         if (at_pos) begin
            data_in = ctrl.value;
         end else if (above_pos) begin
            data_in = left_data;
         end
      end else if (ctrl.del_en) begin
         if (at_pos || above_pos) begin
            data_in = right_data;
         end
      end
   end

   // Match only counts inside the live part of the list
   assign match_in = (data_ff == ctrl.value) && (slot_pos <= ctrl.count);

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (ctrl.loc_en) begin
         match_ff <= match_in;
      end
   end

   assign data_out  = data_ff;
   assign match_out = match_ff;
   // Word at the addressed slot, zero elsewhere, for the removal OR tree
   assign tap_out   = at_pos ? data_ff : '0;

endmodule

// ===== src/plst_locate.sv =====
// plst_locate: lowest-set priority encoder over the cell match flags,
// in two levels of eight. Depends on plst_pkg.
`timescale 1ns / 1ps

module plst_locate
   import plst_pkg::*;
(
   input  logic [CAPACITY-1:0] match_vec,
   output logic                found,
   output logic [CNT_W-1:0]    found_pos
);

   logic [NGRP-1:0]  grp_hit;
   logic [GRP_W-1:0] grp_off [NGRP];

   // First level: lowest match inside each group of eight
   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_hit[g] = 1'b0;
         grp_off[g] = '0;
         for (int j = GRP - 1; j >= 0; j--) begin
            if ((g * GRP + j) < CAPACITY) begin
               if (match_vec[g * GRP + j]) begin
                  grp_hit[g] = 1'b1;
                  grp_off[g] = GRP_W'(j);
               end
            end
         end
      end
   end

   // Second level: lowest group with a hit
   always_comb begin
      found     = 1'b0;
      found_pos = '0;
      for (int g = NGRP - 1; g >= 0; g--) begin
         if (grp_hit[g]) begin
            found     = 1'b1;
            found_pos = CNT_W'(g * GRP) + CNT_W'(grp_off[g]) + CNT_W'(1);
         end
      end
   end

endmodule

// ===== src/positional_list_insert_delete_locate.sv =====
// Positional list: a chain of CAPACITY cells with insert, delete, locate.
// Cells update and match flags register at the accepting edge, with the stage
// payload; the locate encoder then feeds the output register when the stage
// advances. Throughput: one transaction per cycle while the output drains, set
// by the single cell-chain update per edge. Reset (synchronous, active high)
// empties the list and drops pending results; stored words are not cleared.
`timescale 1ns / 1ps

module positional_list_insert_delete_locate
   import plst_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [CMD_W-1:0]         req_command,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_success,
   output logic signed [DATA_W-1:0] rsp_removed_value,
   output logic [POS_W-1:0]         rsp_found_position,
   output logic [POS_W-1:0]         rsp_list_length
);

   logic                req_acc;
   logic [CMP_W-1:0]    pos_x, cnt_x;
   logic                ins_ok, del_ok, is_loc;
   cell_ctrl_type       ctrl;

   logic [CNT_W-1:0]    count_ff, count_in;

   logic [DATA_W-1:0]   cell_data [CAPACITY];
   logic [DATA_W-1:0]   cell_tap  [CAPACITY];
   logic [CAPACITY-1:0] match_vec;
   logic [DATA_W-1:0]   removed_word;

   logic                loc_found;
   logic [CNT_W-1:0]    loc_pos;

   // Middle stage
   logic                stage_valid_ff, stage_valid_in;
   logic                stage_loc_ff;
   logic                stage_ok_ff;
   logic [DATA_W-1:0]   stage_removed_ff;
   logic [CNT_W-1:0]    stage_len_ff;
   logic                stage_adv;

   // Output register
   logic                out_valid_ff, out_valid_in;
   logic                out_success_ff;
   logic [DATA_W-1:0]   out_removed_ff;
   logic [CNT_W-1:0]    out_found_ff;
   logic [CNT_W-1:0]    out_len_ff;

   // Handshake
   assign stage_adv = stage_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || stage_adv;
   assign req_acc   = req_valid && req_ready;

   // Command decode and range checks
   assign pos_x  = CMP_W'(req_position);
   assign cnt_x  = CMP_W'(count_ff);
   assign ins_ok = (req_command == CMD_INSERT) && (pos_x != '0)
                   && (pos_x <= cnt_x + CMP_W'(1)) && (cnt_x < CMP_W'(CAPACITY));
   assign del_ok = (req_command == CMD_DELETE) && (pos_x != '0) && (pos_x <= cnt_x);
   assign is_loc = (req_command == CMD_LOCATE);

   always_comb begin
      ctrl.ins_en = req_acc && ins_ok;
      ctrl.del_en = req_acc && del_ok;
      ctrl.loc_en = req_acc && is_loc;
      ctrl.pos    = pos_x;
      ctrl.count  = cnt_x;
      ctrl.value  = DATA_W'(req_value);
   end

   // Cell chain
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_d, right_d;
      if (i == 0) begin : g_first
         assign left_d = '0;
      end else begin : g_mid_l
         assign left_d = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_d = '0;
      end else begin : g_mid_r
         assign right_d = cell_data[i+1];
      end
      plst_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .cell_index (IDX_W'(i)),
         .left_data  (left_d),
         .right_data (right_d),
         .data_out   (cell_data[i]),
         .match_out  (match_vec[i]),
         .tap_out    (cell_tap[i])
      );
   end

   // Word at the delete position: OR of the one-hot taps
   always_comb begin
      removed_word = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         removed_word = removed_word | cell_tap[i];
      end
   end

   // Locate encoder on the registered match flags
   plst_locate u_locate (
      .match_vec (match_vec),
      .found     (loc_found),
      .found_pos (loc_pos)
   );

   // Entry count
   always_comb begin
      count_in = count_ff;
      if (ctrl.ins_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.del_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign stage_valid_in = req_acc || (stage_valid_ff && !stage_adv);
   assign out_valid_in   = stage_adv || (out_valid_ff && !rsp_ready);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         count_ff       <= count_in;
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // Stage payload, captured at accept
   always_ff @(posedge clock) begin
      if (req_acc) begin
         stage_loc_ff     <= is_loc;
         stage_ok_ff      <= ins_ok || del_ok;
         stage_removed_ff <= del_ok ? removed_word : '0;
         stage_len_ff     <= count_in;
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      if (stage_adv) begin
         out_success_ff <= stage_loc_ff ? loc_found : stage_ok_ff;
         out_removed_ff <= stage_removed_ff;
         out_found_ff   <= (stage_loc_ff && loc_found) ? loc_pos : '0;
         out_len_ff     <= stage_len_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_success        = out_success_ff;
   assign rsp_removed_value  = $signed(out_removed_ff);
   assign rsp_found_position = POS_W'(out_found_ff);
   assign rsp_list_length    = POS_W'(out_len_ff);

`ifndef SYNTHESIS
   // Length never goes past capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(CAPACITY))
      else $error("list length above capacity");

   // Length moves only with an accepted transaction
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !req_acc |=> $stable(count_ff))
      else $error("list length changed without a transaction");

   // A nonzero found position always reports success
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found_position != '0) |-> rsp_success)
      else $error("found position without success");

   // A full stage with a free output must drain
   a_stage_drain: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !out_valid_ff && !req_valid) |=> out_valid_ff)
      else $error("stage failed to drain");
`endif

endmodule

// ===== tb/tb_positional_list_insert_delete_locate.sv =====
// Self-checking testbench for the positional list: a directed opening, then
// random grow/shrink phases, checked against an in-bench list predictor.
// Depends on plst_pkg and positional_list_insert_delete_locate.
`timescale 1ns / 1ps

module tb_positional_list_insert_delete_locate;
   import plst_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS   = 1500;
   localparam int CALM_TAIL      = 150;   // last transactions run without idling
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;

   typedef struct {
      logic [CMD_W-1:0]         command;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
   } list_command_type;

   typedef struct {
      logic                     success;
      logic signed [DATA_W-1:0] removed_value;
      logic [POS_W-1:0]         found_position;
      logic [POS_W-1:0]         list_length;
   } list_response_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [CMD_W-1:0]         req_command = '0;
   logic [POS_W-1:0]         req_position = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_success;
   logic signed [DATA_W-1:0] rsp_removed_value;
   logic [POS_W-1:0]         rsp_found_position;
   logic [POS_W-1:0]         rsp_list_length;

   positional_list_insert_delete_locate dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_success        (rsp_success),
      .rsp_removed_value  (rsp_removed_value),
      .rsp_found_position (rsp_found_position),
      .rsp_list_length    (rsp_list_length)
   );

   always #4 clock = ~clock;

   // Commands waiting to be driven, and responses owed by the block
   list_command_type  pending_cmds[$];
   list_response_type list_responses_due[$];
   list_command_type  active_cmd;

   // Predicted list contents
   logic signed [DATA_W-1:0] list_words [0:CAPACITY-1];
   int                       list_count = 0;

   // Length seen by the generator, to aim positions at the live range
   int gen_len = 0;
   logic signed [DATA_W-1:0] hot_values [0:7];

   int  mismatch_count = 0;
   int  idle_cycles = 0;
   int  drv_gap = 0;
   int  mon_stall = 0;
   bit  drv_idle_on = 1'b1;
   bit  mon_idle_on = 1'b1;

   // Apply one command to the predicted list and return its response
   function automatic list_response_type apply_list_command(list_command_type c);
      list_response_type r;
      int                p;
      int                k;
      r.success        = 1'b0;
      r.removed_value  = '0;
      r.found_position = '0;
      p = c.position;
      case (c.command)
         CMD_INSERT: begin
            if (p >= 1 && p <= list_count + 1 && list_count < CAPACITY) begin
               for (k = list_count; k >= p; k--)
                  list_words[k] = list_words[k-1];
               list_words[p-1] = c.value;
               list_count++;
               r.success = 1'b1;
            end
         end
         CMD_DELETE: begin
            if (p >= 1 && p <= list_count) begin
               r.removed_value = list_words[p-1];
               for (k = p; k < list_count; k++)
                  list_words[k-1] = list_words[k];
               list_count--;
               r.success = 1'b1;
            end
         end
         CMD_LOCATE: begin
            for (k = 0; k < list_count; k++) begin
               if (!r.success && list_words[k] == c.value) begin
                  r.success        = 1'b1;
                  r.found_position = POS_W'(k + 1);
               end
            end
         end
         default: ;
      endcase
      r.list_length = POS_W'(list_count);
      return r;
   endfunction

   task automatic queue_command(input logic [CMD_W-1:0] c, input int p,
                                input logic signed [DATA_W-1:0] v);
      list_command_type item;
      item.command  = c;
      item.position = p[POS_W-1:0];
      item.value    = v;
      pending_cmds.push_back(item);
      if (c == CMD_INSERT && p >= 1 && p <= gen_len + 1 && gen_len < CAPACITY)
         gen_len++;
      else if (c == CMD_DELETE && p >= 1 && p <= gen_len)
         gen_len--;
   endtask

   // Request driver: holds each transaction until accepted, random gaps between
   always @(posedge clock) begin : req_driver
      logic drive_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         drive_valid = req_valid;
         if (req_valid && req_ready) begin
            list_responses_due.push_back(apply_list_command(active_cmd));
            drive_valid = 1'b0;
            if ($urandom_range(0, 39) == 0)
               drv_idle_on = !drv_idle_on;
         end
         if (!drive_valid) begin
            if (drv_gap != 0) begin
               drv_gap--;
            end else if (pending_cmds.size() != 0) begin
               if (pending_cmds.size() >= CALM_TAIL && drv_idle_on &&
                   $urandom_range(0, 3) == 0) begin
                  drv_gap = $urandom_range(0, 7);
               end else begin
                  active_cmd = pending_cmds.pop_front();
                  req_command  <= active_cmd.command;
                  req_position <= active_cmd.position;
                  req_value    <= active_cmd.value;
                  drive_valid = 1'b1;
               end
            end
         end
         req_valid <= drive_valid;
      end
   end

   // Response monitor: checks each transaction against the oldest prediction
   always @(posedge clock) begin : rsp_monitor
      list_response_type exp_rsp;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (list_responses_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("tb: unexpected response ok=%0b rm=%0d pos=%0d len=%0d",
                           rsp_success, rsp_removed_value, rsp_found_position,
                           rsp_list_length);
            end else begin
               exp_rsp = list_responses_due.pop_front();
               if (rsp_success !== exp_rsp.success ||
                   rsp_removed_value !== exp_rsp.removed_value ||
                   rsp_found_position !== exp_rsp.found_position ||
                   rsp_list_length !== exp_rsp.list_length) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display({"tb: mismatch exp ok=%0b rm=%0d pos=%0d len=%0d",
                               " got ok=%0b rm=%0d pos=%0d len=%0d"},
                              exp_rsp.success, exp_rsp.removed_value,
                              exp_rsp.found_position, exp_rsp.list_length,
                              rsp_success, rsp_removed_value,
                              rsp_found_position, rsp_list_length);
               end
            end
            if ($urandom_range(0, 39) == 0)
               mon_idle_on = !mon_idle_on;
         end
         // Backpressure bursts, none in the tail of the run
         if (mon_stall != 0) begin
            mon_stall--;
            rsp_ready <= 1'b0;
         end else if (pending_cmds.size() >= CALM_TAIL && mon_idle_on &&
                      $urandom_range(0, 4) == 0) begin
            mon_stall = $urandom_range(0, 7);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid === 1'b1 && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus and end of run
   initial begin : stimulus
      int  n;
      int  roll;
      int  p;
      int  phase_left;
      bit  grow;
      logic [CMD_W-1:0]         c;
      logic signed [DATA_W-1:0] v;

      hot_values[0] = 32'sd0;
      hot_values[1] = -32'sd1;
      hot_values[2] = 32'h7FFF_FFFF;
      hot_values[3] = 32'h8000_0000;
      hot_values[4] = 32'sd5;
      hot_values[5] = 32'sd1;
      hot_values[6] = 32'sd100;
      hot_values[7] = -32'sd100;

      // Directed: empty-list corner cases
      queue_command(CMD_LOCATE, 0, 32'sd0);           // absent on empty list
      queue_command(CMD_DELETE, 1, 32'sd0);           // delete from empty list
      queue_command(CMD_INSERT, 0, 32'sd1);           // position zero
      queue_command(CMD_INSERT, 2, 32'sd1);           // past length+1
      // Build: front, end, middle, duplicates
      queue_command(CMD_INSERT, 1, 32'h7FFF_FFFF);
      queue_command(CMD_INSERT, 1, 32'h8000_0000);
      queue_command(CMD_INSERT, 3, -32'sd1);
      queue_command(CMD_INSERT, 2, 32'sd0);
      queue_command(CMD_INSERT, 5, 32'sd5);
      queue_command(CMD_INSERT, 1, 32'sd5);
      queue_command(CMD_LOCATE, 0, 32'sd5);           // lowest of two matches
      queue_command(CMD_LOCATE, 64, 32'h7FFF_FFFF);
      queue_command(CMD_LOCATE, 1, -32'sd1);
      queue_command(CMD_LOCATE, 127, 32'sd1234);      // absent
      queue_command(CMD_DELETE, 0, 32'sd0);
      queue_command(CMD_DELETE, 7, 32'sd0);           // one past the end
      queue_command(CMD_DELETE, 127, -32'sd1);
      queue_command(CMD_UNUSED, 127, -32'sd1);
      queue_command(CMD_DELETE, 6, 32'sd0);           // last entry
      queue_command(CMD_DELETE, 1, 32'sd0);           // first entry
      queue_command(CMD_DELETE, 2, 32'sd0);
      queue_command(CMD_INSERT, 127, 32'sd7);
      queue_command(CMD_LOCATE, 0, 32'h8000_0000);

      // Random: alternating grow and shrink phases so the list fills and drains
      grow = 1'b1;
      phase_left = $urandom_range(150, 300);
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (phase_left == 0) begin
            grow = !grow;
            phase_left = $urandom_range(150, 300);
         end
         phase_left--;
         roll = $urandom_range(0, 99);
         v = ($urandom_range(0, 99) < 40) ? hot_values[$urandom_range(0, 7)]
                                          : $urandom;
         if (roll < 2) begin
            c = CMD_UNUSED;
            p = $urandom_range(0, 127);
         end else if (roll < 10) begin
            c = CMD_LOCATE;
            p = $urandom_range(0, 127);
         end else if ((roll < 82) == grow) begin
            c = CMD_INSERT;
            if ($urandom_range(0, 99) < 85)
               p = $urandom_range(1, gen_len + 1);
            else
               p = $urandom_range(0, 1) ? 0 : $urandom_range(gen_len + 2, 127);
         end else begin
            c = CMD_DELETE;
            if ($urandom_range(0, 99) < 85 && gen_len > 0)
               p = $urandom_range(1, gen_len);
            else
               p = $urandom_range(0, 1) ? 0 : $urandom_range(gen_len + 1, 127);
         end
         queue_command(c, p, v);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Drain, then wait a while for any stray response
      while (pending_cmds.size() != 0 || req_valid || list_responses_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/plst_pkg.sv
src/plst_cell.sv
src/plst_locate.sv
src/positional_list_insert_delete_locate.sv
tb/tb_positional_list_insert_delete_locate.sv
